@@ hw/rtl/agab_pkg.sv @@
// Package for the affine-gap alignment block: widths, configuration register
// codes, channel payload types and the saturating arithmetic helpers.
// No dependencies; every other file of the block but agab_ram imports it.
package agab_pkg;

    localparam int DATA_W            = 16;
    localparam int COST_W            = 15;
    localparam int NUM_CELLS         = 4;
    localparam int DIR_W             = 4;
    localparam int QUERY_MAX_DEFAULT = 1024;

    localparam logic [COST_W-1:0] GAP_OPEN_RESET   = COST_W'(16);
    localparam logic [COST_W-1:0] GAP_EXTEND_RESET = COST_W'(4);

    typedef enum logic [0:0] {
        REG_GAP_OPEN   = 1'b0,
        REG_GAP_EXTEND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              first_row;
        logic              last_row;
        logic              restart;
        logic [DATA_W-1:0] f_start;
        logic [DATA_W-1:0] h_start;
        logic [DATA_W-1:0] cost0;
        logic [DATA_W-1:0] cost1;
        logic [DATA_W-1:0] cost2;
        logic [DATA_W-1:0] cost3;
    } req_data_t;

    typedef struct packed {
        logic [DIR_W*NUM_CELLS-1:0] dir_bits;
        logic [DATA_W-1:0]          score0;
        logic [DATA_W-1:0]          score1;
        logic [DATA_W-1:0]          score2;
        logic [DATA_W-1:0]          score3;
        logic                       row_done_last;
    } res_data_t;

    // Per-cell control: update commits the cell's row state, first_row
    // selects the block start values instead of the stored ones.
    typedef struct packed {
        logic update;
        logic first_row;
    } cell_ctl_t;

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [DATA_W-1:0] umin(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ hw/rtl/agab_if.sv @@
// Request and result channel interfaces of the alignment block.
// Depends on agab_pkg for the payload types.
interface agab_req_if;
    import agab_pkg::*;

    logic      valid;
    logic      ready;
    req_data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface agab_res_if;
    import agab_pkg::*;

    logic      valid;
    logic      ready;
    res_data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/agab_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// A read of the address written in the same cycle returns the old contents.
module agab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/agab_cell.sv @@
// One Gotoh cell: combines diagonal H, column gap F and row gap E with the
// substitution cost, and keeps its own diagonal and column-F registers.
// Depends on agab_pkg.
module agab_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  agab_pkg::cell_ctl_t             ctl,
    input  logic [agab_pkg::COST_W-1:0]     gap_open,
    input  logic [agab_pkg::COST_W-1:0]     gap_extend,
    input  logic [agab_pkg::DATA_W-1:0]     diag_start,
    input  logic [agab_pkg::DATA_W-1:0]     f_start,
    input  logic [agab_pkg::DATA_W-1:0]     h_left,
    input  logic [agab_pkg::DATA_W-1:0]     e_in,
    input  logic [agab_pkg::DATA_W-1:0]     cost,
    output logic [agab_pkg::DATA_W-1:0]     h_out,
    output logic [agab_pkg::DATA_W-1:0]     e_out,
    output logic [agab_pkg::DIR_W-1:0]      dir
);
    import agab_pkg::*;

    logic [DATA_W-1:0] diag_reg;
    logic [DATA_W-1:0] colf_reg;
    logic [DATA_W-1:0] q16;
    logic [DATA_W-1:0] r16;
    logic [DATA_W-1:0] diag;
    logic [DATA_W-1:0] f_cur;
    logic [DATA_W-1:0] w_sum;
    logic [DATA_W-1:0] x_hf;
    logic [DATA_W-1:0] x_h;
    logic [DATA_W-1:0] hq;
    logic [DATA_W-1:0] f_next;

    assign q16 = DATA_W'(gap_open);
    assign r16 = DATA_W'(gap_extend);

    always_comb
    begin
        diag   = ctl.first_row ? diag_start : diag_reg;
        f_cur  = ctl.first_row ? f_start : colf_reg;
        w_sum  = sat_add(diag, cost);
        x_hf   = umin(w_sum, f_cur);
        x_h    = umin(x_hf, e_in);
        hq     = sat_add(x_h, q16);
        f_next = umin(hq, sat_add(f_cur, r16));
        e_out  = umin(hq, sat_add(e_in, r16));
        h_out  = x_h;
        dir[0] = (w_sum == x_hf);
        dir[1] = (x_h == e_in);
        dir[2] = (hq == f_next);
        dir[3] = (hq == e_out);
    end

    // The diagonal for the next row is the H that the left neighbor produced
    // on this row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= '0;
            colf_reg <= '0;
        end
        else if (ctl.update)
        begin
            diag_reg <= h_left;
            colf_reg <= f_next;
        end
    end

endmodule

@@ hw/rtl/affine_gap_align_block_unit.sv @@
// Affine-gap alignment block, four cells wide, one query row per request.
// A request passes the preparation stage, each cell stage and the result register.
// Throughput: one request per cycle while results are taken; a row that reads a store
// entry still being updated by one of the up to five rows ahead of it waits for the write.
// Reset: control state, cell registers and offsets clear, gap costs return to
// 16 and 4; the row store is not cleared and is undefined until written.
module affine_gap_align_block_unit #(
    parameter int QUERY_MAX = agab_pkg::QUERY_MAX_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    agab_req_if.sink                     req,
    agab_res_if.source                   result,
    input  logic                         cfg_we,
    input  agab_pkg::cfg_reg_t           cfg_index,
    input  logic [agab_pkg::COST_W-1:0]  cfg_data
);
    import agab_pkg::*;

    localparam int IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUERY_MAX - 1);

    // Payload carried alongside a row as it walks through the cells. Stage c
    // holds the inputs of cell c.
    typedef struct packed {
        logic                             first_row;
        logic                             last_row;
        logic [IDX_W-1:0]                 idx;
        logic [DATA_W-1:0]                h_left;
        logic [DATA_W-1:0]                e_val;
        logic [DATA_W-1:0]                f_chain;
        logic [DATA_W-1:0]                d_start;
        logic [NUM_CELLS-1:0][DATA_W-1:0] cost;
        logic [NUM_CELLS-1:0][DATA_W-1:0] h_done;
        logic [DIR_W*NUM_CELLS-1:0]       dir;
    } stage_t;

    // Configuration registers. Change them only while the block is idle (not enforced).
    logic [COST_W-1:0] gap_open_reg;
    logic [COST_W-1:0] gap_extend_reg;
    logic [DATA_W-1:0] q16;
    logic [DATA_W-1:0] r16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_open_reg   <= GAP_OPEN_RESET;
            gap_extend_reg <= GAP_EXTEND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAP_OPEN:   gap_open_reg   <= cfg_data;
                REG_GAP_EXTEND: gap_extend_reg <= cfg_data;
                default:        gap_open_reg   <= gap_open_reg;
            endcase
        end
    end

    assign q16 = DATA_W'(gap_open_reg);
    assign r16 = DATA_W'(gap_extend_reg);

    // The whole pipeline moves together. It advances whenever the result
    // register is empty or its contents are being taken this cycle, so a new
    // request can enter in the cycle in which a finished result is taken.
    logic             advance;
    logic             accept;
    logic             hazard;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] row_index_reg;
    logic [IDX_W-1:0] row_index_next;

    logic             s0_valid_reg;
    req_data_t        s0_data_reg;
    logic [IDX_W-1:0] s0_idx_reg;

    logic             stage_valid_reg [NUM_CELLS];
    stage_t           stage_reg       [NUM_CELLS];
    stage_t           stage_next      [NUM_CELLS+1];

    logic             res_valid_reg;
    res_data_t        res_data_reg;

    assign advance = !res_valid_reg || result.ready;

    // A first row rewinds the store index. The index wraps after QUERY_MAX rows.
    assign rd_idx         = req.data.first_row ? '0 : row_index_reg;
    assign row_index_next = (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;

    // Read-after-write interlock. The H and E values of an entry are written
    // when the row leaves the last cell; a younger row that needs the same
    // entry must not read it before then. A restarting row ignores the stored
    // values, so it never has to wait.
    always_comb
    begin
        hazard = s0_valid_reg && (s0_idx_reg == rd_idx);
        for (int s = 0; s < NUM_CELLS; s++)
        begin
            if (stage_valid_reg[s] && (stage_reg[s].idx == rd_idx))
            begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && !req.data.restart;
    end

    assign req.ready = advance && !hazard;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg <= '0;
        end
        else if (accept)
        begin
            row_index_reg <= row_index_next;
        end
    end

    // Row store: H in the upper half of each word, E in the lower half. The
    // read is issued when the request is accepted and its registered data is
    // used in the preparation stage.
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [2*DATA_W-1:0]     ram_wdata;
    logic [2*DATA_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]       cell_h [NUM_CELLS];
    logic [DATA_W-1:0]       cell_e [NUM_CELLS];
    logic [DIR_W-1:0]        cell_dir [NUM_CELLS];

    assign ram_we    = advance && stage_valid_reg[NUM_CELLS-1];
    assign ram_waddr = stage_reg[NUM_CELLS-1].idx;
    assign ram_wdata = {cell_h[NUM_CELLS-1], cell_e[NUM_CELLS-1]};

    agab_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (QUERY_MAX)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Preparation stage: holds the accepted request while the store read is
    // under way. Since reads are only issued on an accept, the RAM's read
    // register keeps this row's data through any stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && accept)
        begin
            s0_data_reg <= req.data;
            s0_idx_reg  <= rd_idx;
        end
    end

    // Restart offset. A first row sets it to Q for a restarting block and to
    // zero otherwise. A restarting row replaces the stored H by the offset and
    // the stored E by the offset plus Q, then the offset grows by R. A row
    // without restart adds the offset to the stored values as they are.
    logic [DATA_W-1:0] restart_offset_reg;
    logic [DATA_W-1:0] offset_cur;
    logic [DATA_W-1:0] offset_next;
    logic [DATA_W-1:0] store_h;
    logic [DATA_W-1:0] store_e;
    logic [DATA_W-1:0] prep_h;
    logic [DATA_W-1:0] prep_e;

    assign store_h = ram_rdata[2*DATA_W-1:DATA_W];
    assign store_e = ram_rdata[DATA_W-1:0];

    always_comb
    begin
        if (s0_data_reg.first_row)
        begin
            offset_cur = s0_data_reg.restart ? q16 : '0;
        end
        else
        begin
            offset_cur = restart_offset_reg;
        end
        if (s0_data_reg.restart)
        begin
            prep_h      = offset_cur;
            prep_e      = sat_add(offset_cur, q16);
            offset_next = sat_add(offset_cur, r16);
        end
        else
        begin
            prep_h      = sat_add(store_h, offset_cur);
            prep_e      = sat_add(store_e, offset_cur);
            offset_next = offset_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_offset_reg <= '0;
        end
        else if (advance && s0_valid_reg)
        begin
            restart_offset_reg <= offset_next;
        end
    end

    // Inputs of cell 0. On a first row cell 0 takes h_start as its diagonal
    // and f_start as its column F; later cells derive their start values from
    // f_start as the row moves along.
    always_comb
    begin
        stage_next[0].first_row = s0_data_reg.first_row;
        stage_next[0].last_row  = s0_data_reg.last_row;
        stage_next[0].idx       = s0_idx_reg;
        stage_next[0].h_left    = prep_h;
        stage_next[0].e_val     = prep_e;
        stage_next[0].f_chain   = s0_data_reg.f_start;
        stage_next[0].d_start   = s0_data_reg.h_start;
        stage_next[0].cost[0]   = s0_data_reg.cost0;
        stage_next[0].cost[1]   = s0_data_reg.cost1;
        stage_next[0].cost[2]   = s0_data_reg.cost2;
        stage_next[0].cost[3]   = s0_data_reg.cost3;
        stage_next[0].h_done    = '0;
        stage_next[0].dir       = '0;
    end

    // Cell pipeline. Each cell works on the row in its own stage; it only
    // depends on the previous row's values that it keeps itself and on the
    // E value and H that the left cell passed along with this row, so one
    // row can enter every cycle while the pipeline advances.
    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        cell_ctl_t ctl;
        stage_t    nxt;
        logic      valid_in;

        assign ctl.update    = advance && stage_valid_reg[c];
        assign ctl.first_row = stage_reg[c].first_row;

        agab_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .gap_open   (gap_open_reg),
            .gap_extend (gap_extend_reg),
            .diag_start (stage_reg[c].d_start),
            .f_start    (stage_reg[c].f_chain),
            .h_left     (stage_reg[c].h_left),
            .e_in       (stage_reg[c].e_val),
            .cost       (stage_reg[c].cost[c]),
            .h_out      (cell_h[c]),
            .e_out      (cell_e[c]),
            .dir        (cell_dir[c])
        );

        // First-row start values for the next cell: F grows by R per cell,
        // the diagonal of cell 1 is f_start minus Q and then grows by R.
        always_comb
        begin
            nxt                    = stage_reg[c];
            nxt.h_left             = cell_h[c];
            nxt.e_val              = cell_e[c];
            nxt.f_chain            = sat_add(stage_reg[c].f_chain, r16);
            nxt.h_done[c]          = cell_h[c];
            nxt.dir[DIR_W*c +: DIR_W] = cell_dir[c];
            if (c == 0)
            begin
                nxt.d_start = sat_sub(stage_reg[c].f_chain, q16);
            end
            else
            begin
                nxt.d_start = sat_add(stage_reg[c].d_start, r16);
            end
        end

        assign stage_next[c+1] = nxt;

        // Cell 0 takes its row from the preparation stage, the others from
        // the cell to their left.
        if (c == 0)
        begin : g_head
            assign valid_in = s0_valid_reg;
        end
        else
        begin : g_tail
            assign valid_in = stage_valid_reg[c-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[c] <= 1'b0;
            end
            else if (advance)
            begin
                stage_valid_reg[c] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[c] <= stage_next[c];
            end
        end
    end

    // Result register. Scores are the final H values of the four cells and
    // are only shown on the last row; otherwise they read as zero.
    res_data_t res_data_next;

    always_comb
    begin
        res_data_next.dir_bits      = stage_next[NUM_CELLS].dir;
        res_data_next.row_done_last = stage_next[NUM_CELLS].last_row;
        if (stage_next[NUM_CELLS].last_row)
        begin
            res_data_next.score0 = stage_next[NUM_CELLS].h_done[0];
            res_data_next.score1 = stage_next[NUM_CELLS].h_done[1];
            res_data_next.score2 = stage_next[NUM_CELLS].h_done[2];
            res_data_next.score3 = stage_next[NUM_CELLS].h_done[3];
        end
        else
        begin
            res_data_next.score0 = '0;
            res_data_next.score1 = '0;
            res_data_next.score2 = '0;
            res_data_next.score3 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= stage_valid_reg[NUM_CELLS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg[NUM_CELLS-1])
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

endmodule

@@ hw/rtl/agab_checker.sv @@
// Port-level checks for the alignment block, attached by the bind below.
// Depends on agab_pkg and on the top level affine_gap_align_block_unit.
module agab_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input agab_pkg::res_data_t res_data
);
    import agab_pkg::*;

    // A result that is not taken stays offered with the same contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed or dropped while stalled");

    // Scores are only shown on the last row of a block.
    a_scores_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.row_done_last |->
            res_data.score0 == '0 && res_data.score1 == '0 &&
            res_data.score2 == '0 && res_data.score3 == '0)
        else $error("nonzero score on a row that is not the last");

    // Once reset has been seen low at an edge, nothing is offered at the next one.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result offered during reset");

endmodule

bind affine_gap_align_block_unit agab_checker u_agab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
